// ----- sv/bls_pkg.sv -----
// Shared types and codes for the bounded list block.
`default_nettype none
package bls_pkg;

  localparam int KindW  = 2;
  localparam int StatW  = 2;
  localparam int ValueW = 32;
  localparam int PosW   = 7;

  localparam logic [KindW-1:0] KIND_APPEND = 2'd0;
  localparam logic [KindW-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KindW-1:0] KIND_SEARCH = 2'd2;
  localparam logic [KindW-1:0] KIND_SHOW   = 2'd3;

  localparam logic [StatW-1:0] ST_OK       = 2'd0;
  localparam logic [StatW-1:0] ST_FULL     = 2'd1;
  localparam logic [StatW-1:0] ST_EMPTY    = 2'd2;
  localparam logic [StatW-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic             load_op;
    logic             wr_en;
    logic             cnt_inc;
    logic             cnt_dec;
    logic             idx_clr;
    logic             idx_inc;
    logic             rd_en;
    logic             out_load;
    logic [StatW-1:0] out_status;
    logic             out_sel_value;
    logic             out_sel_pos;
    logic             out_last;
  } cmd_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             is_empty;
    logic             is_full;
    logic             match;
    logic             at_tail;
    logic             out_free;
  } stat_t;

endpackage
`default_nettype wire

// ----- sv/bls_ctrl.sv -----
// Controller state machine for the bounded list block.
`default_nettype none
module bls_ctrl (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  output logic           in_stall,
  input  bls_pkg::stat_t st,
  output bls_pkg::cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_op = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st.kind)
          bls_pkg::KIND_APPEND: begin
            if (st.out_free) begin
              cmd.out_load   = 1'b1;
              cmd.out_last   = 1'b1;
              cmd.out_status = st.is_full ? bls_pkg::ST_FULL : bls_pkg::ST_OK;
              cmd.wr_en      = !st.is_full;
              cmd.cnt_inc    = !st.is_full;
              state_next     = S_IDLE;
            end
          end
          bls_pkg::KIND_REMOVE: begin
            if (st.out_free) begin
              cmd.out_load   = 1'b1;
              cmd.out_last   = 1'b1;
              cmd.out_status = st.is_empty ? bls_pkg::ST_EMPTY : bls_pkg::ST_OK;
              cmd.cnt_dec    = !st.is_empty;
              state_next     = S_IDLE;
            end
          end
          default: begin
            priority if (st.is_empty) begin
              if (st.out_free) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = bls_pkg::ST_EMPTY;
                state_next     = S_IDLE;
              end
            end else begin
              cmd.idx_clr = 1'b1;
              cmd.rd_en   = 1'b1;
              state_next  = S_SCAN;
            end
          end
        endcase
      end
      S_SCAN: begin
        priority if (st.kind == bls_pkg::KIND_SHOW) begin
          if (st.out_free) begin
            cmd.out_load      = 1'b1;
            cmd.out_status    = bls_pkg::ST_OK;
            cmd.out_sel_value = 1'b1;
            cmd.out_last      = st.at_tail;
            if (st.at_tail) begin
              state_next = S_IDLE;
            end else begin
              cmd.idx_inc = 1'b1;
              cmd.rd_en   = 1'b1;
            end
          end
        end else if (st.match) begin
          if (st.out_free) begin
            cmd.out_load    = 1'b1;
            cmd.out_status  = bls_pkg::ST_OK;
            cmd.out_sel_pos = 1'b1;
            cmd.out_last    = 1'b1;
            state_next      = S_IDLE;
          end
        end else if (st.at_tail) begin
          if (st.out_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = bls_pkg::ST_NOTFOUND;
            cmd.out_last   = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          cmd.rd_en   = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/bls_dpath.sv -----
// Datapath of the bounded list block: entry memory, count, scan index and output register.
`default_nettype none
module bls_dpath #(
  parameter int DEPTH = 32
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  bls_pkg::cmd_t                         cmd,
  output bls_pkg::stat_t                        st,
  input  wire         [bls_pkg::KindW-1:0]      kind,
  input  wire  signed [bls_pkg::ValueW-1:0]     value,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic        [bls_pkg::StatW-1:0]      status,
  output logic signed [bls_pkg::ValueW-1:0]     item_value,
  output logic        [bls_pkg::PosW-1:0]       position,
  output logic                                  last
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [bls_pkg::ValueW-1:0] mem [DEPTH];
  logic signed [bls_pkg::ValueW-1:0] rdata;
  logic        [bls_pkg::KindW-1:0]  op_kind;
  logic signed [bls_pkg::ValueW-1:0] op_value;
  logic        [CntW-1:0]            count;
  logic        [IdxW-1:0]            idx;
  logic        [IdxW-1:0]            rd_addr;
  logic                              out_free;

  assign out_free = !out_valid || !out_stall;
  assign rd_addr  = cmd.idx_clr ? '0 : idx + IdxW'(1);

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[count[IdxW-1:0]] <= op_value;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op_kind  <= kind;
      op_value <= value;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CntW'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status     <= cmd.out_status;
      item_value <= cmd.out_sel_value ? rdata : '0;
      position   <= cmd.out_sel_pos ? bls_pkg::PosW'(idx) + bls_pkg::PosW'(1) : '0;
      last       <= cmd.out_last;
    end
  end

  always_comb begin
    st.kind     = op_kind;
    st.is_empty = (count == '0);
    st.is_full  = (count == CntW'(DEPTH));
    st.match    = (rdata == op_value);
    st.at_tail  = (CntW'(idx) + CntW'(1) == count);
    st.out_free = out_free;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("Entry count exceeds the store depth.");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("Output register loaded while a stalled beat is held.");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (count != CntW'(DEPTH)) && cmd.cnt_inc)
    else $error("Store written without room or without a count update.");

  a_dec_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> (count != '0))
    else $error("Remove taken on an empty list.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid after reset.");

endmodule
`default_nettype wire

// ----- sv/bounded_list_stack_with_search_core.sv -----
// Top level of the bounded list with tail append, tail remove, search and show.
// The block holds up to DEPTH signed 32-bit values in order. Each input beat on the
// in channel carries a kind (append, remove tail, search, show) and a value.
// An input beat is taken when in_valid is high and in_stall is low; in_stall is
// high while an item is being worked on, so one item is handled at a time.
// Result beats leave on the out channel with status, item_value, position and
// last; a beat moves when out_valid is high and out_stall is low, and last marks
// the final beat of each item.
// Append and remove load their result beat from the decode state once the output
// register is free, and the block then returns to idle to take the next item.
// Search reads one stored entry per cycle through the single memory read port,
// starting at the first entry and stopping at the first match or at the tail.
// Show emits one beat per cycle from the same read port while out_stall is low,
// and an empty list gives a single empty beat.
// When the receiver stalls, the output register holds its beat and the next result
// waits to be loaded; nothing is lost or repeated.
// Reset clears the count and the output valid; stored values need no clearing.
`default_nettype none
module bounded_list_stack_with_search_core #(
  parameter int DEPTH = 32
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire         [bls_pkg::KindW-1:0]  kind,
  input  wire  signed [bls_pkg::ValueW-1:0] value,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic        [bls_pkg::StatW-1:0]  status,
  output logic signed [bls_pkg::ValueW-1:0] item_value,
  output logic        [bls_pkg::PosW-1:0]   position,
  output logic                              last
);

  bls_pkg::cmd_t  cmd;
  bls_pkg::stat_t st;

  bls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  bls_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .kind       (kind),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .item_value (item_value),
    .position   (position),
    .last       (last)
  );

endmodule
`default_nettype wire
